FILE: rtl/core/box_downsample_2x2_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2x2 box downsampler
// Shared concurrent assertion wrappers, clocked on clock; BDS_ASSERT is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOX_DOWNSAMPLE_2X2_TOP_DEFINES_SVH
`define BOX_DOWNSAMPLE_2X2_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked at every rising edge outside reset.
`define BDS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Property checked at every rising edge, reset included.
`define BDS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define BDS_ASSERT(lbl, prop, msg)
`define BDS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/bds_pkg.sv
// ----------------------------------------------------------------------------
// bds_pkg
// Widths, register indexes and shared types of the 2x2 box downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bds_pkg;

   localparam int PIXEL_W           = 16;
   localparam int SUM_W             = 17;
   localparam int SIZE_W            = 11;
   localparam int ROW_W             = 10;
   localparam int HEIGHT_LIMIT      = 1024;
   localparam int SIZE_RESET        = 1024;
   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int CSR_IDX_W         = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // Position of the pixel being accepted.
   typedef struct packed {
      logic col_odd;
      logic row_odd;
      logic last_col;
      logic last_row;
   } pos_flags_type;

   // How the second stage finishes one result item.
   typedef struct packed {
      logic       use_line;
      logic [1:0] shift;
      logic       row_end;
      logic       frame_end;
   } avg_cmd_type;

   // Zero acts as one, and values above the limit saturate at the limit.
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input int unsigned limit);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (32'(v) > limit) begin
         r = SIZE_W'(limit);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bds_cfg_pos.sv
// ----------------------------------------------------------------------------
// bds_cfg_pos
// Size registers and the raster position counters.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_downsample_2x2_top_defines.svh"

module bds_cfg_pos #(
   parameter int MAX_WIDTH = bds_pkg::DEFAULT_MAX_WIDTH,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [bds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bds_pkg::SIZE_W-1:0]     csr_wdata,
   input  wire logic                           advance,
   output logic      [COL_W-1:0]               col,
   output bds_pkg::pos_flags_type              flags
);
   import bds_pkg::*;

   localparam int CMP_W = ((COL_W > SIZE_W) ? COL_W : SIZE_W) + 1;

   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              last_col, last_row;

   assign last_col = (CMP_W'(col_ff) + CMP_W'(1)) >= CMP_W'(width_ff);
   assign last_row = ({1'b0, row_ff} + SIZE_W'(1)) >= height_ff;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (advance) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      // A size write restarts the frame.
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = clamp_size(csr_wdata, MAX_WIDTH);
               col_in   = '0;
               row_in   = '0;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = clamp_size(csr_wdata, HEIGHT_LIMIT);
               col_in    = '0;
               row_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_size(SIZE_W'(SIZE_RESET), MAX_WIDTH);
         height_ff <= clamp_size(SIZE_W'(SIZE_RESET), HEIGHT_LIMIT);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   assign col            = col_ff;
   assign flags.col_odd  = col_ff[0];
   assign flags.row_odd  = row_ff[0];
   assign flags.last_col = last_col;
   assign flags.last_row = last_row;

   `BDS_ASSERT(a_col_in_row, CMP_W'(col_ff) < CMP_W'(width_ff), "column beyond row width")
   `BDS_ASSERT(a_row_in_frame, {1'b0, row_ff} < height_ff, "row beyond frame height")
   `BDS_ASSERT(a_wrap_row_start, advance && !csr_we && last_col |=> col_ff == '0,
      "column did not wrap after the last pixel of a row")

endmodule

`default_nettype wire

FILE: rtl/core/bds_line_store.sv
// ----------------------------------------------------------------------------
// bds_line_store
// Single-port line memory of column-pair sums with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_line_store #(
   parameter int MAX_WIDTH = bds_pkg::DEFAULT_MAX_WIDTH,
   parameter int DEPTH     = (MAX_WIDTH + 1) / 2,
   parameter int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic                             rd_en,
   input  wire logic        [ADDR_W-1:0]         addr,
   input  wire logic signed [bds_pkg::SUM_W-1:0] wr_data,
   output logic signed      [bds_pkg::SUM_W-1:0] rd_data
);
   import bds_pkg::*;

   logic signed [SUM_W-1:0] mem [DEPTH];
   logic signed [SUM_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

FILE: rtl/core/bds_out_stage.sv
// ----------------------------------------------------------------------------
// bds_out_stage
// Second stage: adds the line sum, floors the mean, and holds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_downsample_2x2_top_defines.svh"

module bds_out_stage (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               load,
   input  wire bds_pkg::avg_cmd_type               cmd,
   input  wire logic signed [bds_pkg::SUM_W-1:0]   partial,
   input  wire logic signed [bds_pkg::SUM_W-1:0]   line_sum,
   output logic                                    can_load,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed      [bds_pkg::PIXEL_W-1:0] rsp_avg_pixel,
   output logic                                    rsp_row_end,
   output logic                                    rsp_frame_end
);
   import bds_pkg::*;

   logic                      s2_valid_ff, s2_valid_in;
   avg_cmd_type               s2_cmd_ff;
   logic signed [SUM_W-1:0]   s2_partial_ff;
   logic                      out_valid_ff, out_valid_in;
   logic signed [PIXEL_W-1:0] out_avg_ff;
   logic                      out_row_end_ff, out_frame_end_ff;
   logic                      out_free, s2_move;
   logic signed [SUM_W:0]     total;
   logic signed [SUM_W:0]     mean;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign s2_move  = s2_valid_ff && out_free;
   assign can_load = !s2_valid_ff || out_free;

   // The line sum register is held from the edge that loaded this stage.
   assign total = (SUM_W+1)'(s2_partial_ff)
                + (s2_cmd_ff.use_line ? (SUM_W+1)'(line_sum) : '0);
   assign mean  = total >>> s2_cmd_ff.shift;

   assign s2_valid_in  = load || (s2_valid_ff && !s2_move);
   assign out_valid_in = s2_move || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s2_cmd_ff     <= cmd;
         s2_partial_ff <= partial;
      end
      if (s2_move) begin
         out_avg_ff       <= mean[PIXEL_W-1:0];
         out_row_end_ff   <= s2_cmd_ff.row_end;
         out_frame_end_ff <= s2_cmd_ff.frame_end;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_avg_pixel = out_avg_ff;
   assign rsp_row_end   = out_row_end_ff;
   assign rsp_frame_end = out_frame_end_ff;

   `BDS_ASSERT(a_no_overrun, load |-> can_load, "second stage loaded while full and blocked")
   `BDS_ASSERT(a_s2_holds, s2_valid_ff && !out_free && !load |=> s2_valid_ff,
      "second stage dropped an item while the output was blocked")
   `BDS_ASSERT(a_frame_end_row_end, out_valid_ff && out_frame_end_ff |-> out_row_end_ff,
      "frame end without row end")

endmodule

`default_nettype wire

FILE: rtl/core/box_downsample_2x2_top.sv
// ----------------------------------------------------------------------------
// box_downsample_2x2_top
// 2x2 box-average downsampler for a raster stream of signed Q8.8 pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel item per clock in raster order while req_stall is
// low and returns one result item per 2x2 block, so a frame of image_height by
// image_width pixels yields ceil(rows/2) by ceil(cols/2) results. At an odd
// right or bottom edge the partial block averages only the pixels that exist,
// and every mean is floored (arithmetic shift). The sustained rate is one
// pixel per clock while the output is not stalled: each pixel makes exactly
// one access to a single-port line memory, a write of its column-pair sum in
// even rows or a read in odd rows. After its last pixel is accepted, a result
// is registered in the second stage and then in the output register. While
// the output is stalled, the second stage can still take one more result, and
// pixels that make no result keep flowing until that stage is full; then the
// input is held off until the output moves again. A size register write
// restarts the frame at row 0, column 0; a zero size acts as one and sizes
// above the limits saturate. The line memory needs no clearing pass, because
// every entry read in an odd row was written in the row above.
// ----------------------------------------------------------------------------
`default_nettype none

module box_downsample_2x2_top #(
   parameter int MAX_WIDTH = bds_pkg::DEFAULT_MAX_WIDTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Configuration writes.
   input  wire logic                               csr_we,
   input  wire logic        [bds_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [bds_pkg::SIZE_W-1:0]  csr_wdata,
   // Pixel items in.
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [bds_pkg::PIXEL_W-1:0] req_pixel,
   // Result items out.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed      [bds_pkg::PIXEL_W-1:0] rsp_avg_pixel,
   output logic                                    rsp_row_end,
   output logic                                    rsp_frame_end
);
   import bds_pkg::*;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   logic [COL_W-1:0]          col;
   pos_flags_type             flags;
   logic                      accept;
   logic                      can_load;
   logic                      emit;
   avg_cmd_type               cmd;
   logic signed [SUM_W-1:0]   partial;
   logic signed [SUM_W-1:0]   line_sum;
   logic signed [PIXEL_W-1:0] left_pixel_ff;
   logic [ADDR_W-1:0]         line_addr;

   // The input is held off only while the second stage is full and blocked.
   assign req_stall = !can_load;
   assign accept    = req_valid && can_load;

   bds_cfg_pos #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W)
   ) u_cfg_pos (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (accept),
      .col       (col),
      .flags     (flags)
   );

   // The pixel at an even column waits here for its right-hand neighbor.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_pixel_ff <= '0;
      end else if (accept && !flags.col_odd) begin
         left_pixel_ff <= req_pixel;
      end
   end

   // At an odd column the partial sum is the horizontal pair; otherwise the
   // pixel alone. Even rows store it, odd rows add the stored sum above.
   assign partial = flags.col_odd ? (SUM_W'(left_pixel_ff) + SUM_W'(req_pixel))
                                  : SUM_W'(req_pixel);

   always_comb begin
      cmd.row_end   = flags.last_col;
      cmd.frame_end = flags.last_col && flags.last_row;
      cmd.use_line  = flags.row_odd;
      if (!flags.row_odd) begin
         if (!flags.col_odd) begin
            // Lone pixel in the bottom-right corner.
            emit      = flags.last_col && flags.last_row;
            cmd.shift = 2'd0;
         end else begin
            // Bottom row of an odd-height frame: horizontal pair only.
            emit      = flags.last_row;
            cmd.shift = 2'd1;
         end
      end else begin
         if (!flags.col_odd) begin
            // Right edge of an odd-width row: vertical pair only.
            emit      = flags.last_col;
            cmd.shift = 2'd1;
         end else begin
            emit      = 1'b1;
            cmd.shift = 2'd2;
         end
      end
   end

   assign line_addr = ADDR_W'(col >> 1);

   bds_line_store #(
      .MAX_WIDTH (MAX_WIDTH),
      .DEPTH     (LINE_DEPTH),
      .ADDR_W    (ADDR_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept && !flags.row_odd),
      .rd_en   (accept && flags.row_odd),
      .addr    (line_addr),
      .wr_data (partial),
      .rd_data (line_sum)
   );

   bds_out_stage u_out_stage (
      .clock         (clock),
      .reset         (reset),
      .load          (accept && emit),
      .cmd           (cmd),
      .partial       (partial),
      .line_sum      (line_sum),
      .can_load      (can_load),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_avg_pixel (rsp_avg_pixel),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire
